>>> rtl/hkvt_pkg.sv
// Shared types and constants for the hash keyed value table.
// Beat structs, command codes, slot layout and default sizes.
// No dependencies.
package hkvt_pkg;

    localparam int HASH_W      = 64;
    localparam int TYPE_W      = 3;
    localparam int PAYLOAD_W   = 64;
    localparam int CMD_W       = 2;
    localparam int COUNT_W     = 7;
    localparam int DEF_BUCKETS = 16;
    localparam int DEF_WAYS    = 4;

    localparam logic [CMD_W-1:0] CMD_PUT    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GET    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]     command;
        logic [HASH_W-1:0]    key_hash;
        logic [TYPE_W-1:0]    value_type;
        logic [PAYLOAD_W-1:0] value_payload;
    } t_in_beat;

    typedef struct packed {
        logic                 found;
        logic [TYPE_W-1:0]    result_type;
        logic [PAYLOAD_W-1:0] result_payload;
        logic [COUNT_W-1:0]   element_count;
        logic                 overflow;
    } t_out_beat;

    typedef struct packed {
        logic [HASH_W-1:0]    hash;
        logic [TYPE_W-1:0]    vtype;
        logic [PAYLOAD_W-1:0] payload;
    } t_slot;

    // Outcome of one command on a bucket row.
    typedef struct packed {
        logic found;
        logic overflow;
        logic inc;          // new entry inserted
        logic dec;          // entry removed
        logic row_write;    // slot data changes
        logic valid_write;  // valid bits change
    } t_row_status;

endpackage

>>> rtl/hash_keyed_value_table.sv
// Top level of the hash keyed value table: command sequencer, count, result register.
// Instantiates hkvt_bucket_index, hkvt_table_mem and hkvt_row_update.
// Depends on hkvt_pkg.
//
//   beat      direction  handshake                   payload
//   command   in         i_in_valid / o_in_ready     i_in_beat  (hkvt_pkg::t_in_beat)
//   result    out        o_out_valid / i_out_ready   o_out_beat (hkvt_pkg::t_out_beat)
//
// Put, get and remove pass through accept, index register and row
// read-modify-write when BUCKETS is a power of two; other bucket counts add
// the four-bit-per-cycle modulo unit before the row read. Clear walks the
// valid-bit memory one row a cycle.
// After reset the same walk runs with o_in_ready low.
// A finished result sits in the output register; the next command is accepted
// while it waits, and only the write-back or the end of a clear stalls until the register is free.
module hash_keyed_value_table #(
    parameter int BUCKETS = hkvt_pkg::DEF_BUCKETS,
    parameter int WAYS    = hkvt_pkg::DEF_WAYS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  hkvt_pkg::t_in_beat   i_in_beat,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output hkvt_pkg::t_out_beat  o_out_beat
);
    import hkvt_pkg::*;

    localparam int IDX_W = $clog2(BUCKETS);
    localparam int SLOTS = BUCKETS * WAYS;
    localparam logic [IDX_W-1:0] LAST_ROW = IDX_W'(BUCKETS - 1);

    typedef enum logic [4:0] {
        ST_INIT  = 5'b00001,   // valid-bit wipe after reset
        ST_IDLE  = 5'b00010,
        ST_INDEX = 5'b00100,   // waiting on the bucket index
        ST_EXEC  = 5'b01000,   // row data present, write back and report
        ST_CLEAR = 5'b10000    // valid-bit wipe for a clear command
    } t_state;

    t_state             r_state, n_state;
    t_in_beat           r_cmd;
    logic [IDX_W-1:0]   r_bucket;
    logic [IDX_W-1:0]   r_sweep;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_out_valid;
    t_out_beat          r_out;

    logic               in_fire;
    logic               out_free;
    logic               sweeping;
    logic               sweep_last;
    logic               exec_fire;
    logic               clear_fire;
    logic               idx_start;
    logic               idx_done;
    logic [IDX_W-1:0]   idx_index;
    logic               rd_en;
    logic               data_wr_en;
    logic               valid_wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [WAYS-1:0]    wr_valid;

    t_slot [WAYS-1:0]   mem_row;
    logic  [WAYS-1:0]   mem_valid;
    t_slot [WAYS-1:0]   upd_row;
    logic  [WAYS-1:0]   upd_valid;
    logic [TYPE_W-1:0]  upd_type;
    logic [PAYLOAD_W-1:0] upd_payload;
    t_row_status        upd_status;

    // Handshake and sequencing strobes.
    assign in_fire    = i_in_valid && (r_state == ST_IDLE);
    assign out_free   = !r_out_valid || i_out_ready;
    assign sweeping   = (r_state == ST_INIT) || (r_state == ST_CLEAR);
    assign sweep_last = (r_sweep == LAST_ROW);
    assign idx_start  = in_fire && (i_in_beat.command != CMD_CLEAR);
    assign rd_en      = (r_state == ST_INDEX) && idx_done;
    assign exec_fire  = (r_state == ST_EXEC) && out_free;
    assign clear_fire = (r_state == ST_CLEAR) && sweep_last && out_free;

    // Write port: the sweep zeroes valid rows, otherwise the modified row goes back.
    assign data_wr_en  = exec_fire && upd_status.row_write;
    assign valid_wr_en = sweeping || (exec_fire && upd_status.valid_write);
    assign wr_addr     = sweeping ? r_sweep : r_bucket;
    assign wr_valid    = sweeping ? '0 : upd_valid;

    assign n_count = r_count + COUNT_W'(upd_status.inc) - COUNT_W'(upd_status.dec);

    hkvt_bucket_index #(
        .BUCKETS (BUCKETS),
        .IDX_W   (IDX_W)
    ) u_index (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (idx_start),
        .i_hash  (i_in_beat.key_hash),
        .o_done  (idx_done),
        .o_index (idx_index)
    );

    hkvt_table_mem #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS),
        .IDX_W   (IDX_W)
    ) u_mem (
        .i_clk         (i_clk),
        .i_rd_en       (rd_en),
        .i_rd_addr     (idx_index),
        .o_rd_row      (mem_row),
        .o_rd_valid    (mem_valid),
        .i_data_wr_en  (data_wr_en),
        .i_valid_wr_en (valid_wr_en),
        .i_wr_addr     (wr_addr),
        .i_wr_row      (upd_row),
        .i_wr_valid    (wr_valid)
    );

    hkvt_row_update #(
        .WAYS (WAYS)
    ) u_update (
        .i_cmd     (r_cmd.command),
        .i_hash    (r_cmd.key_hash),
        .i_type    (r_cmd.value_type),
        .i_payload (r_cmd.value_payload),
        .i_row     (mem_row),
        .i_valid   (mem_valid),
        .o_row     (upd_row),
        .o_valid   (upd_valid),
        .o_type    (upd_type),
        .o_payload (upd_payload),
        .o_status  (upd_status)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                if (sweep_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = (i_in_beat.command == CMD_CLEAR) ? ST_CLEAR : ST_INDEX;
                end
            end
            ST_INDEX: begin
                if (idx_done) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_CLEAR: begin
                if (clear_fire) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_sweep     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_fire) begin
                r_sweep <= '0;
            end else if (sweeping && !sweep_last) begin
                r_sweep <= r_sweep + 1'b1;
            end
            if (exec_fire) begin
                r_count <= n_count;
            end else if (clear_fire) begin
                r_count <= '0;
            end
            if (exec_fire || clear_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd <= i_in_beat;
        end
        if (rd_en) begin
            r_bucket <= idx_index;
        end
        if (exec_fire) begin
            r_out.found          <= upd_status.found;
            r_out.result_type    <= upd_type;
            r_out.result_payload <= upd_payload;
            r_out.element_count  <= n_count;
            r_out.overflow       <= upd_status.overflow;
        end else if (clear_fire) begin
            r_out <= '0;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    // The index unit reports only for a command that is waiting on it.
    a_index_done_in_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        idx_done |-> (r_state == ST_INDEX))
        else $error("bucket index finished outside the index wait");

    // Valid bits change only during a sweep or a write-back.
    a_valid_write_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        valid_wr_en |-> (sweeping || (r_state == ST_EXEC)))
        else $error("valid memory written outside sweep or write-back");

    // The count never runs past the number of slots.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (SLOTS >= (1 << COUNT_W)) || (int'(r_count) <= SLOTS))
        else $error("element count exceeds slot total");

    // A dropped put cannot also report a hit.
    a_overflow_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.overflow && r_out.found))
        else $error("result flags overflow together with found");

    // A completed clear reports an empty table.
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clear_fire |=> (r_count == '0) && r_out_valid)
        else $error("clear left a nonzero count");

endmodule

>>> rtl/hkvt_bucket_index.sv
// Bucket index unit: key hash modulo BUCKETS, one result per start.
// Power-of-two sizes take the low bits; others reduce four bits a cycle.
// Depends on hkvt_pkg.
module hkvt_bucket_index #(
    parameter int BUCKETS = hkvt_pkg::DEF_BUCKETS,
    parameter int IDX_W   = $clog2(BUCKETS)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [hkvt_pkg::HASH_W-1:0] i_hash,
    output logic                      o_done,
    output logic [IDX_W-1:0]          o_index
);
    import hkvt_pkg::*;

    logic             r_done;
    logic [IDX_W-1:0] r_index;

    assign o_done  = r_done;
    assign o_index = r_index;

    generate
        if ((BUCKETS & (BUCKETS - 1)) == 0) begin : g_pow2
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done <= 1'b0;
                end else begin
                    r_done <= i_start;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_index <= i_hash[IDX_W-1:0];
                end
            end
        end else begin : g_serial
            localparam int DIGIT_W = 4;
            localparam int DIGITS  = HASH_W / DIGIT_W;
            localparam int CNT_W   = $clog2(DIGITS);
            localparam logic [IDX_W:0] MODULUS = (IDX_W + 1)'(BUCKETS);

            logic              r_busy;
            logic [CNT_W-1:0]  r_cnt;
            logic [HASH_W-1:0] r_shift;
            logic [IDX_W-1:0]  r_rem;
            logic [IDX_W-1:0]  n_rem;
            logic [IDX_W:0]    step_rem;

            // Restoring reduction, one hash bit per step, MSB first.
            always_comb begin
                step_rem = {1'b0, r_rem};
                for (int k = 0; k < DIGIT_W; k++) begin
                    step_rem = {step_rem[IDX_W-1:0], r_shift[HASH_W-1-k]};
                    if (step_rem >= MODULUS) begin
                        step_rem = step_rem - MODULUS;
                    end
                end
                n_rem = step_rem[IDX_W-1:0];
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_busy <= 1'b0;
                    r_cnt  <= '0;
                    r_done <= 1'b0;
                end else begin
                    r_done <= 1'b0;
                    if (i_start) begin
                        r_busy <= 1'b1;
                        r_cnt  <= '0;
                    end else if (r_busy) begin
                        r_cnt <= r_cnt + 1'b1;
                        if (r_cnt == CNT_W'(DIGITS - 1)) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                        end
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_shift <= i_hash;
                    r_rem   <= '0;
                end else if (r_busy) begin
                    r_shift <= {r_shift[HASH_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                    r_rem   <= n_rem;
                    r_index <= n_rem;
                end
            end
        end
    endgenerate

endmodule

>>> rtl/hkvt_table_mem.sv
// Bucket storage: a slot data memory and a valid-bit memory, one row per bucket.
// One read port and one write port each, registered read data.
// Depends on hkvt_pkg.
module hkvt_table_mem #(
    parameter int BUCKETS = hkvt_pkg::DEF_BUCKETS,
    parameter int WAYS    = hkvt_pkg::DEF_WAYS,
    parameter int IDX_W   = $clog2(BUCKETS)
) (
    input  logic                          i_clk,
    input  logic                          i_rd_en,
    input  logic [IDX_W-1:0]              i_rd_addr,
    output hkvt_pkg::t_slot [WAYS-1:0]    o_rd_row,
    output logic [WAYS-1:0]               o_rd_valid,
    input  logic                          i_data_wr_en,
    input  logic                          i_valid_wr_en,
    input  logic [IDX_W-1:0]              i_wr_addr,
    input  hkvt_pkg::t_slot [WAYS-1:0]    i_wr_row,
    input  logic [WAYS-1:0]               i_wr_valid
);
    import hkvt_pkg::*;

    t_slot [WAYS-1:0] r_data  [BUCKETS];
    logic  [WAYS-1:0] r_valid [BUCKETS];
    t_slot [WAYS-1:0] r_rd_row;
    logic  [WAYS-1:0] r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_data_wr_en) begin
            r_data[i_wr_addr] <= i_wr_row;
        end
        if (i_rd_en) begin
            r_rd_row <= r_data[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid_wr_en) begin
            r_valid[i_wr_addr] <= i_wr_valid;
        end
        if (i_rd_en) begin
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_row   = r_rd_row;
    assign o_rd_valid = r_rd_valid;

endmodule

>>> rtl/hkvt_row_update.sv
// Bucket row logic: hash match across the ways, free-way pick, modified row.
// Purely combinational; sits between the read and write ports.
// Depends on hkvt_pkg.
module hkvt_row_update #(
    parameter int WAYS = hkvt_pkg::DEF_WAYS
) (
    input  logic [hkvt_pkg::CMD_W-1:0]     i_cmd,
    input  logic [hkvt_pkg::HASH_W-1:0]    i_hash,
    input  logic [hkvt_pkg::TYPE_W-1:0]    i_type,
    input  logic [hkvt_pkg::PAYLOAD_W-1:0] i_payload,
    input  hkvt_pkg::t_slot [WAYS-1:0]     i_row,
    input  logic [WAYS-1:0]                i_valid,
    output hkvt_pkg::t_slot [WAYS-1:0]     o_row,
    output logic [WAYS-1:0]                o_valid,
    output logic [hkvt_pkg::TYPE_W-1:0]    o_type,
    output logic [hkvt_pkg::PAYLOAD_W-1:0] o_payload,
    output hkvt_pkg::t_row_status          o_status
);
    import hkvt_pkg::*;

    logic [WAYS-1:0]      hit_oh;
    logic [WAYS-1:0]      free_oh;
    logic                 hit_any;
    logic                 free_any;
    logic [TYPE_W-1:0]    hit_type;
    logic [PAYLOAD_W-1:0] hit_payload;

    // Lowest matching way and lowest free way, as one-hot vectors.
    always_comb begin
        hit_any     = 1'b0;
        free_any    = 1'b0;
        hit_oh      = '0;
        free_oh     = '0;
        hit_type    = '0;
        hit_payload = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (i_valid[w] && i_row[w].hash == i_hash && !hit_any) begin
                hit_oh[w]   = 1'b1;
                hit_any     = 1'b1;
                hit_type    = i_row[w].vtype;
                hit_payload = i_row[w].payload;
            end
            if (!i_valid[w] && !free_any) begin
                free_oh[w] = 1'b1;
                free_any   = 1'b1;
            end
        end
    end

    always_comb begin
        o_row     = i_row;
        o_valid   = i_valid;
        o_type    = '0;
        o_payload = '0;
        o_status  = '0;
        case (i_cmd)
            CMD_PUT: begin
                o_status.found = hit_any;
                if (hit_any) begin
                    o_status.row_write = 1'b1;
                    for (int w = 0; w < WAYS; w++) begin
                        if (hit_oh[w]) begin
                            o_row[w].vtype   = i_type;
                            o_row[w].payload = i_payload;
                        end
                    end
                end else if (free_any) begin
                    o_status.row_write   = 1'b1;
                    o_status.valid_write = 1'b1;
                    o_status.inc         = 1'b1;
                    for (int w = 0; w < WAYS; w++) begin
                        if (free_oh[w]) begin
                            o_row[w]   = '{hash: i_hash, vtype: i_type, payload: i_payload};
                            o_valid[w] = 1'b1;
                        end
                    end
                end else begin
                    o_status.overflow = 1'b1;
                end
            end
            CMD_GET: begin
                o_status.found = hit_any;
                o_type         = hit_type;
                o_payload      = hit_payload;
            end
            CMD_REMOVE: begin
                o_status.found       = hit_any;
                o_status.valid_write = hit_any;
                o_status.dec         = hit_any;
                o_valid              = i_valid & ~hit_oh;
            end
            default: begin
                // clear is handled by the sweep in the controller
                o_status = '0;
            end
        endcase
    end

endmodule

>>> bench/hash_keyed_value_table_tb.sv
// Testbench for hash_keyed_value_table: directed and random command traffic, checked
// against an in-bench table predictor. Depends on hkvt_pkg and the table RTL only.
`timescale 1ns / 1ps

module hash_keyed_value_table_tb;
    import hkvt_pkg::*;

    localparam int TBL_BUCKETS = DEF_BUCKETS;
    localparam int TBL_WAYS    = DEF_WAYS;
    localparam int TBL_SLOTS   = TBL_BUCKETS * TBL_WAYS;
    // Clear walks one bucket row a cycle; leave room for it plus pipeline.
    localparam int DRAIN_CYCLES = 2 * TBL_BUCKETS + 8;
    localparam int CYCLE_LIMIT  = 400000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_beat  i_in_beat;
    logic      o_out_valid;
    logic      i_out_ready = 1'b1;
    t_out_beat o_out_beat;

    hash_keyed_value_table #(
        .BUCKETS (TBL_BUCKETS),
        .WAYS    (TBL_WAYS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat)
    );

    // Shadow copy of the table contents, updated at each accepted command beat.
    logic              tbl_valid   [TBL_SLOTS];
    logic [HASH_W-1:0] tbl_hash    [TBL_SLOTS];
    logic [TYPE_W-1:0] tbl_type    [TBL_SLOTS];
    logic [63:0]       tbl_payload [TBL_SLOTS];
    int                tbl_count;

    // Results predicted at command acceptance, oldest first.
    t_out_beat pending_results[$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // Keys shared by the directed tests; all land in one bucket.
    logic [HASH_W-1:0] bucket_keys[5];

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Predicts one command's result and applies it to the shadow table.
    function automatic t_out_beat apply_table_command(t_in_beat b);
        t_out_beat r;
        int base;
        int hit;
        int free_slot;
        r         = '0;
        base      = int'(b.key_hash % TBL_BUCKETS) * TBL_WAYS;
        hit       = -1;
        free_slot = -1;
        for (int w = 0; w < TBL_WAYS; w++) begin
            if (tbl_valid[base + w] && tbl_hash[base + w] == b.key_hash && hit < 0)
                hit = base + w;
            if (!tbl_valid[base + w] && free_slot < 0)
                free_slot = base + w;
        end
        case (b.command)
            CMD_PUT: begin
                if (hit >= 0) begin
                    r.found           = 1'b1;
                    tbl_type[hit]     = b.value_type;
                    tbl_payload[hit]  = b.value_payload;
                end else if (free_slot >= 0) begin
                    // new hash takes the lowest free way
                    tbl_valid[free_slot]   = 1'b1;
                    tbl_hash[free_slot]    = b.key_hash;
                    tbl_type[free_slot]    = b.value_type;
                    tbl_payload[free_slot] = b.value_payload;
                    tbl_count++;
                end else begin
                    r.overflow = 1'b1;
                end
            end
            CMD_GET: begin
                if (hit >= 0) begin
                    r.found          = 1'b1;
                    r.result_type    = tbl_type[hit];
                    r.result_payload = tbl_payload[hit];
                end
            end
            CMD_REMOVE: begin
                if (hit >= 0) begin
                    r.found        = 1'b1;
                    tbl_valid[hit] = 1'b0;
                    tbl_count--;
                end
            end
            CMD_CLEAR: begin
                foreach (tbl_valid[s]) tbl_valid[s] = 1'b0;
                tbl_count = 0;
            end
        endcase
        r.element_count = COUNT_W'(tbl_count);
        return r;
    endfunction

    // Sends one command beat. Valid is only lowered when an idle gap follows,
    // so back-to-back beats never see a drop-and-raise in one time step.
    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [HASH_W-1:0] hash,
                            input logic [TYPE_W-1:0] vtype, input logic [63:0] payload);
        t_in_beat b;
        int gap;
        b.command       = cmd;
        b.key_hash      = hash;
        b.value_type    = vtype;
        b.value_payload = payload;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_beat  <= b;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(apply_table_command(b));
    endtask

    task automatic set_pressure(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // Receiver back-pressure.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic report_mismatch(input string field, input logic [63:0] exp_val,
                                   input logic [63:0] got_val);
        $display("%0t: %s mismatch: expected %h, got %h", $time, field, exp_val, got_val);
        mismatch_count++;
    endtask

    // Result beat checker: every accepted result against the oldest prediction.
    always @(posedge i_clk) begin : result_check
        t_out_beat exp_beat;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result beat: expected none, got %h",
                         $time, o_out_beat);
                mismatch_count++;
            end else begin
                exp_beat = pending_results.pop_front();
                if (o_out_beat.found !== exp_beat.found)
                    report_mismatch("found", exp_beat.found, o_out_beat.found);
                if (o_out_beat.result_type !== exp_beat.result_type)
                    report_mismatch("result_type", exp_beat.result_type,
                                    o_out_beat.result_type);
                if (o_out_beat.result_payload !== exp_beat.result_payload)
                    report_mismatch("result_payload", exp_beat.result_payload,
                                    o_out_beat.result_payload);
                if (o_out_beat.element_count !== exp_beat.element_count)
                    report_mismatch("element_count", exp_beat.element_count,
                                    o_out_beat.element_count);
                if (o_out_beat.overflow !== exp_beat.overflow)
                    report_mismatch("overflow", exp_beat.overflow, o_out_beat.overflow);
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Lookups and removes on an empty table miss.
    task automatic test_empty_table();
        send_cmd(CMD_GET, '0, '0, '0);
        send_cmd(CMD_REMOVE, '1, '1, '1);
    endtask

    // Extreme hashes, types and payloads; replace of an existing entry.
    task automatic test_put_get_extremes();
        send_cmd(CMD_PUT, '0, '0, '0);
        send_cmd(CMD_PUT, '1, 3'd7, '1);  // type seven is stored as given
        send_cmd(CMD_GET, '0, '1, '1);
        send_cmd(CMD_GET, '1, '0, '0);
        send_cmd(CMD_PUT, '0, 3'd6, 64'h8000_0000_0000_0001);
        send_cmd(CMD_GET, '0, '0, '0);
    endtask

    // Fill one bucket, overflow it, then replace inside the full bucket.
    task automatic test_bucket_overflow();
        for (int i = 0; i < 5; i++)
            bucket_keys[i] = {28'($urandom), 32'(i + 1), 4'h5};
        for (int i = 0; i < 4; i++)
            send_cmd(CMD_PUT, bucket_keys[i], 3'(i + 1), {$urandom, $urandom});
        send_cmd(CMD_PUT, bucket_keys[4], 3'd2, {$urandom, $urandom});
        send_cmd(CMD_PUT, bucket_keys[2], 3'd4, {$urandom, $urandom});
        send_cmd(CMD_GET, bucket_keys[4], '0, '0);
    endtask

    // Remove frees a way that the next new hash reuses.
    task automatic test_remove_and_reuse();
        send_cmd(CMD_REMOVE, bucket_keys[1], '0, '0);
        send_cmd(CMD_GET, bucket_keys[1], '0, '0);
        send_cmd(CMD_PUT, bucket_keys[4], 3'd5, {$urandom, $urandom});
        send_cmd(CMD_GET, bucket_keys[4], '0, '0);
        send_cmd(CMD_REMOVE, bucket_keys[1], '0, '0);
    endtask

    task automatic test_clear();
        send_cmd(CMD_CLEAR, {$urandom, $urandom}, 3'($urandom_range(7)), {$urandom, $urandom});
        send_cmd(CMD_GET, bucket_keys[0], '0, '0);
        send_cmd(CMD_PUT, '0, 3'd1, 64'd1);
    endtask

    // Fill every way of every bucket (count 64), overflow each bucket once,
    // read everything back, then empty the table one remove at a time.
    task automatic test_fill_table();
        logic [HASH_W-1:0] keys[$];
        logic [HASH_W-1:0] hash;
        send_cmd(CMD_CLEAR, '0, '0, '0);
        for (int b = 0; b < TBL_BUCKETS; b++) begin
            for (int w = 0; w < TBL_WAYS; w++) begin
                hash = {$urandom, $urandom};
                hash = hash - (hash % TBL_BUCKETS) + b;
                keys.push_back(hash);
                send_cmd(CMD_PUT, hash, 3'($urandom_range(7)), {$urandom, $urandom});
            end
        end
        for (int b = 0; b < TBL_BUCKETS; b++) begin
            hash = {$urandom, $urandom};
            send_cmd(CMD_PUT, hash - (hash % TBL_BUCKETS) + b, 3'($urandom_range(7)),
                     {$urandom, $urandom});
        end
        for (int i = keys.size() - 1; i >= 0; i--)
            send_cmd(CMD_GET, keys[i], '0, '0);
        foreach (keys[i])
            send_cmd(CMD_REMOVE, keys[i], '0, '0);
    endtask

    // Mixed traffic over a key pool packed into a few hot buckets, so that
    // hits, replaces, overflows and way reuse all happen often.
    task automatic test_random_traffic(input int n_items, input int pool_size,
                                       input int hot_buckets, input int clear_pct);
        logic [HASH_W-1:0] key_pool[$];
        logic [HASH_W-1:0] hash;
        logic [63:0]       payload;
        logic [CMD_W-1:0]  cmd;
        int                pick;
        int                first_bucket;
        first_bucket = $urandom_range(TBL_BUCKETS - 1);
        for (int i = 0; i < pool_size; i++) begin
            hash = {$urandom, $urandom};
            hash = hash - (hash % TBL_BUCKETS)
                 + (first_bucket + $urandom_range(hot_buckets - 1)) % TBL_BUCKETS;
            key_pool.push_back(hash);
        end
        repeat (n_items) begin
            pick = $urandom_range(99);
            if (pick < clear_pct)
                cmd = CMD_CLEAR;
            else if (pick < 50)
                cmd = CMD_PUT;
            else if (pick < 78)
                cmd = CMD_GET;
            else
                cmd = CMD_REMOVE;
            if ($urandom_range(9) < 8)
                hash = key_pool[$urandom_range(pool_size - 1)];
            else
                hash = {$urandom, $urandom};
            case ($urandom_range(7))
                0:       payload = '0;
                1:       payload = '1;
                default: payload = {$urandom, $urandom};
            endcase
            send_cmd(cmd, hash, 3'($urandom_range(7)), payload);
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_beat  = '0;
        foreach (tbl_valid[s]) begin
            tbl_valid[s]   = 1'b0;
            tbl_hash[s]    = '0;
            tbl_type[s]    = '0;
            tbl_payload[s] = '0;
        end
        tbl_count = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_pressure(0, 0);
        test_empty_table();
        test_put_get_extremes();
        test_bucket_overflow();
        test_remove_and_reuse();
        test_clear();
        test_fill_table();

        set_pressure(0, 0);
        test_random_traffic(360, 24, 4, 2);
        set_pressure(75, 0);
        test_random_traffic(360, 80, 16, 1);
        set_pressure(0, 75);
        test_random_traffic(360, 40, 8, 3);
        set_pressure(30, 30);
        test_random_traffic(360, 60, 16, 2);

        // Drain: all predictions consumed, then a quiet tail for stray beats.
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> files.f
rtl/hkvt_pkg.sv
rtl/hkvt_bucket_index.sv
rtl/hkvt_table_mem.sv
rtl/hkvt_row_update.sv
rtl/hash_keyed_value_table.sv
bench/hash_keyed_value_table_tb.sv
